// File: hdl/tlmf_pkg.sv
// ----------------------------------------------------------------------------
// Tabu list move filter package
// Shared constants, payload types and state encoding for the tabu list move
// filter and its memories.
// ----------------------------------------------------------------------------
package tlmf_pkg;

  localparam int PROBLEM_SIZE    = 32;
  localparam int IDX_W           = $clog2(PROBLEM_SIZE);
  localparam int PAIR_CELLS      = PROBLEM_SIZE * PROBLEM_SIZE;
  localparam int PAIR_AW         = 2 * IDX_W;
  localparam int MAX_TABU_PERIOD = 64;
  localparam int SLOT_W          = $clog2(MAX_TABU_PERIOD);
  localparam int PERIOD_W        = 7;
  localparam int CNT_W           = 7;
  localparam int COST_W          = 32;
  localparam int PADDR_W         = 3;

  localparam logic [CNT_W-1:0]    COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [PAIR_AW-1:0]  CLR_LAST  = PAIR_AW'(PAIR_CELLS - 1);
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = PERIOD_W'(MAX_TABU_PERIOD);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd16;

  localparam logic [1:0] FUNC_QUERY  = 2'd0;
  localparam logic [1:0] FUNC_COMMIT = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic REG_TABU_PERIOD = 1'b0;
  localparam logic REG_ASP_THRESH  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_Q_WAIT,
    ST_C_RING,
    ST_C_DEC,
    ST_C_RDNEW,
    ST_C_INC,
    ST_DONE
  } tlmf_state_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [IDX_W-1:0]  move_row;
    logic [IDX_W-1:0]  move_col;
    logic [COST_W-1:0] current_cost;
    logic [COST_W-1:0] move_cost;
  } tlmf_req_t;

  typedef struct packed {
    logic is_tabu;
    logic aspiration_met;
  } tlmf_rsp_t;

  function automatic logic [PERIOD_W-1:0] eff_period(input logic [PERIOD_W-1:0] p);
    logic [PERIOD_W-1:0] r;
    r = p;
    if (p == '0) begin
      r = PERIOD_W'(1);
    end else if (p > PERIOD_MAX) begin
      r = PERIOD_MAX;
    end
    return r;
  endfunction

endpackage

// File: hdl/tlmf_ram.sv
// ----------------------------------------------------------------------------
// Tabu list move filter RAM
// Simple dual-port synchronous RAM with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module tlmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/tabu_list_move_filter.sv
// ----------------------------------------------------------------------------
// Tabu list move filter
// Recency tabu list for pair-swap local search, with a move ring and a
// per-pair count memory, both updated by read-modify-write sequences.
// ----------------------------------------------------------------------------
// A query reads the pair count and registers the result.
// A commit increments the new pair's count, after decrementing the retired pair's count
// when the retired ring slot is valid, each a read-modify-write pass on the count memory.
// A clear sweeps the 1024-entry count memory.
// One transaction is in flight at a time; the next waits until its result is registered.
// After reset the same clearing sweep runs before the first item.
// ----------------------------------------------------------------------------
module tabu_list_move_filter
  import tlmf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  tlmf_req_t          req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output tlmf_rsp_t          rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  tlmf_state_t state, state_next;

  logic [PERIOD_W-1:0]     tabu_period;
  logic [COST_W-1:0]       asp_threshold;
  logic [PAIR_AW-1:0]      clr_cnt;
  logic                    clr_item;
  tlmf_req_t               item;
  logic [SLOT_W-1:0]       slot;
  logic [PAIR_AW-1:0]      old_idx;
  logic [SLOT_W-1:0]       oldest_slot;
  logic [MAX_TABU_PERIOD-1:0] ring_valid;
  tlmf_rsp_t               pend;

  logic [PERIOD_W-1:0] period;
  logic [SLOT_W-1:0]   commit_slot;
  logic [PERIOD_W-1:0] slot_inc;
  logic [SLOT_W-1:0]   slot_next;
  logic [PAIR_AW-1:0]  new_idx;
  logic [COST_W-1:0]   limit;
  tlmf_rsp_t           q_result;
  logic                out_free;
  logic                accept;

  logic                cnt_we;
  logic [PAIR_AW-1:0]  cnt_waddr;
  logic [CNT_W-1:0]    cnt_wdata;
  logic [PAIR_AW-1:0]  cnt_raddr;
  logic [CNT_W-1:0]    cnt_rdata;
  logic                ring_we;
  logic [SLOT_W-1:0]   ring_raddr;
  logic [PAIR_AW-1:0]  ring_rdata;

  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_ASP_THRESH) ? asp_threshold
                                                  : {{(32-PERIOD_W){1'b0}}, tabu_period};
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  assign period      = eff_period(tabu_period);
  assign commit_slot = ({1'b0, oldest_slot} >= period) ? '0 : oldest_slot;
  assign slot_inc    = {1'b0, slot} + PERIOD_W'(1);
  assign slot_next   = (slot_inc >= period) ? '0 : slot_inc[SLOT_W-1:0];
  assign new_idx     = {item.move_row, item.move_col};

  assign limit                  = item.current_cost - asp_threshold;
  assign q_result.is_tabu       = (cnt_rdata != '0);
  assign q_result.aspiration_met = (item.move_cost < limit);

  tlmf_ram #(
    .WIDTH (PAIR_AW),
    .DEPTH (MAX_TABU_PERIOD)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (slot),
    .wdata (new_idx),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  tlmf_ram #(
    .WIDTH (CNT_W),
    .DEPTH (PAIR_CELLS)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (req.func)
            FUNC_QUERY:  state_next = ST_Q_WAIT;
            FUNC_COMMIT: state_next = ST_C_RING;
            FUNC_CLEAR:  state_next = ST_CLEAR;
            default:     state_next = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_cnt == CLR_LAST) begin
          state_next = clr_item ? ST_DONE : ST_IDLE;
        end
      end
      ST_Q_WAIT:  state_next = out_free ? ST_IDLE : ST_DONE;
      ST_C_RING:  state_next = ring_valid[slot] ? ST_C_DEC : ST_C_INC;
      ST_C_DEC:   state_next = ST_C_RDNEW;
      ST_C_RDNEW: state_next = ST_C_INC;
      ST_C_INC:   state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_we     = 1'b0;
    cnt_waddr  = clr_cnt;
    cnt_wdata  = '0;
    cnt_raddr  = new_idx;
    ring_we    = 1'b0;
    ring_raddr = commit_slot;
    case (state)
      ST_IDLE: begin
        cnt_raddr = {req.move_row, req.move_col};
      end
      ST_CLEAR: begin
        cnt_we = 1'b1;
      end
      ST_C_RING: begin
        cnt_raddr = ring_valid[slot] ? ring_rdata : new_idx;
      end
      ST_C_DEC: begin
        cnt_we    = 1'b1;
        cnt_waddr = old_idx;
        cnt_wdata = (cnt_rdata == '0) ? '0 : cnt_rdata - CNT_W'(1);
      end
      ST_C_INC: begin
        cnt_we    = 1'b1;
        cnt_waddr = new_idx;
        cnt_wdata = (cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + CNT_W'(1);
        ring_we   = 1'b1;
      end
      default: begin
        cnt_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_cnt       <= '0;
      clr_item      <= 1'b0;
      oldest_slot   <= '0;
      ring_valid    <= '0;
      tabu_period   <= PERIOD_RESET;
      asp_threshold <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_TABU_PERIOD) begin
          tabu_period <= pwdata[PERIOD_W-1:0];
        end else begin
          asp_threshold <= pwdata;
        end
      end

      if (accept && req.func == FUNC_CLEAR) begin
        clr_cnt     <= '0;
        clr_item    <= 1'b1;
        ring_valid  <= '0;
        oldest_slot <= '0;
      end

      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + PAIR_AW'(1);
      end

      if (state == ST_C_INC) begin
        ring_valid[slot] <= 1'b1;
        oldest_slot      <= slot_next;
      end

      if ((state == ST_Q_WAIT || state == ST_DONE) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
      slot <= commit_slot;
      pend <= '0;
    end
    if (state == ST_C_RING) begin
      old_idx <= ring_rdata;
    end
    if (state == ST_Q_WAIT) begin
      pend <= q_result;
    end
    if ((state == ST_Q_WAIT || state == ST_DONE) && out_free) begin
      rsp <= (state == ST_Q_WAIT) ? q_result : pend;
    end
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !cnt_we && !ring_we)
    else $error("Memory write while idle.");

  a_slot_in_period: assert property (@(posedge clk) disable iff (rst)
    (state == ST_C_INC) |=> ({1'b0, oldest_slot} < period))
    else $error("Oldest slot outside the tabu period after a commit.");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && clr_cnt == CLR_LAST && clr_item) |=> (state == ST_DONE))
    else $error("Clear sweep did not end in a result.");

  a_commit_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_C_INC) |=> (pend == '0))
    else $error("Commit produced a nonzero result.");

endmodule

// File: tb/sv/tabu_list_move_filter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tabu list move filter checker
// Watches the request, response and register ports of the filter. It keeps
// its own copy of the move ring, the pair counts and the registers, predicts
// the response of every accepted request, and compares each accepted
// response with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tabu_list_move_filter_checker
  import tlmf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_stall,
  input  tlmf_req_t          req,
  input  logic               rsp_valid,
  input  logic               rsp_stall,
  input  tlmf_rsp_t          rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);

  localparam logic [PADDR_W-1:0] ADDR_PERIOD = PADDR_W'(4 * int'(REG_TABU_PERIOD));
  localparam logic [PADDR_W-1:0] ADDR_THRESH = PADDR_W'(4 * int'(REG_ASP_THRESH));

  logic [IDX_W-1:0]    slot_row [MAX_TABU_PERIOD];
  logic [IDX_W-1:0]    slot_col [MAX_TABU_PERIOD];
  logic                slot_used [MAX_TABU_PERIOD];
  logic [CNT_W-1:0]    pair_cnt [PAIR_CELLS];
  int unsigned         next_slot;
  logic [PERIOD_W-1:0] period_reg;
  logic [COST_W-1:0]   thresh_reg;
  tlmf_rsp_t           expected_rsps [$];
  int                  errors = 0;

  function automatic int unsigned period_in_use();
    if (period_reg == '0) return 1;
    if (int'(period_reg) > MAX_TABU_PERIOD) return MAX_TABU_PERIOD;
    return int'(period_reg);
  endfunction

  task automatic wipe_list();
    for (int i = 0; i < MAX_TABU_PERIOD; i++) begin
      slot_used[i] = 1'b0;
      slot_row[i]  = '0;
      slot_col[i]  = '0;
    end
    for (int i = 0; i < PAIR_CELLS; i++) begin
      pair_cnt[i] = '0;
    end
    next_slot = 0;
  endtask

  task automatic record_move(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
    int unsigned span;
    int unsigned pair_idx;
    span = period_in_use();
    if (next_slot >= span) next_slot = 0;
    if (slot_used[next_slot]) begin
      pair_idx = int'(slot_row[next_slot]) * PROBLEM_SIZE + int'(slot_col[next_slot]);
      if (pair_cnt[pair_idx] != '0) pair_cnt[pair_idx] = pair_cnt[pair_idx] - CNT_W'(1);
    end
    slot_row[next_slot]  = row;
    slot_col[next_slot]  = col;
    slot_used[next_slot] = 1'b1;
    pair_idx = int'(row) * PROBLEM_SIZE + int'(col);
    if (pair_cnt[pair_idx] != COUNT_MAX) pair_cnt[pair_idx] = pair_cnt[pair_idx] + CNT_W'(1);
    next_slot = next_slot + 1;
    if (next_slot >= span) next_slot = 0;
  endtask

  task automatic predict_response(input tlmf_req_t item, output tlmf_rsp_t answer);
    logic [COST_W-1:0] bar;
    answer = '0;
    case (item.func)
      FUNC_QUERY: begin
        bar = item.current_cost - thresh_reg;
        answer.is_tabu = pair_cnt[int'(item.move_row) * PROBLEM_SIZE + int'(item.move_col)] != '0;
        answer.aspiration_met = item.move_cost < bar;
      end
      FUNC_COMMIT: begin
        record_move(item.move_row, item.move_col);
      end
      FUNC_CLEAR: begin
        wipe_list();
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : monitor
    tlmf_rsp_t want;
    tlmf_rsp_t got;
    if (rst) begin
      period_reg = PERIOD_RESET;
      thresh_reg = '0;
      wipe_list();
      expected_rsps.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_PERIOD) begin
          period_reg = pwdata[PERIOD_W-1:0];
        end else if (paddr == ADDR_THRESH) begin
          thresh_reg = pwdata;
        end
      end
      if (rsp_valid && !rsp_stall) begin
        got = rsp;
        if (expected_rsps.size() == 0) begin
          errors++;
          $display("%0t: response with no request outstanding: expected none, actual %b",
                   $time, got);
        end else begin
          want = expected_rsps.pop_front();
          if (got.is_tabu !== want.is_tabu) begin
            errors++;
            $display("%0t: is_tabu mismatch: expected %b, actual %b",
                     $time, want.is_tabu, got.is_tabu);
          end
          if (got.aspiration_met !== want.aspiration_met) begin
            errors++;
            $display("%0t: aspiration_met mismatch: expected %b, actual %b",
                     $time, want.aspiration_met, got.aspiration_met);
          end
        end
      end
      if (req_valid && !req_stall) begin
        predict_response(req, want);
        expected_rsps.push_back(want);
      end
    end
    fail_count <= errors;
    pending    <= expected_rsps.size();
  end

endmodule

// File: tb/sv/tabu_list_move_filter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tabu list move filter testbench
// Drives directed and random query, commit, clear and idle-code requests
// through the filter under a series of period and threshold settings, with
// random idling on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tabu_list_move_filter_tb;
  import tlmf_pkg::*;

  localparam logic [1:0]         FUNC_NOP       = 2'd3;
  localparam logic [PADDR_W-1:0] ADDR_PERIOD    = PADDR_W'(4 * int'(REG_TABU_PERIOD));
  localparam logic [PADDR_W-1:0] ADDR_THRESH    = PADDR_W'(4 * int'(REG_ASP_THRESH));
  localparam int                 WATCHDOG_LIMIT = 6000;
  localparam int                 PHASE_ITEMS    = 210;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  tlmf_req_t          req       = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  tlmf_rsp_t          rsp;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [31:0]        pwdata    = '0;
  logic [31:0]        prdata;
  logic               pready;

  int                fail_count;
  int                pending;
  bit                calm_tail  = 1'b0;
  int                gap_pct    = 20;
  logic [COST_W-1:0] cur_thresh = '0;
  int                n_query    = 0;
  int                n_commit   = 0;
  int                n_clear    = 0;
  int                n_nop      = 0;
  int                n_settings = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tabu_list_move_filter i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  tabu_list_move_filter_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic tlmf_req_t pack_request(input logic [1:0] f, input int row, input int col,
                                             input logic [COST_W-1:0] cur,
                                             input logic [COST_W-1:0] mcost);
    tlmf_req_t item;
    item.func         = f;
    item.move_row     = IDX_W'(row);
    item.move_col     = IDX_W'(col);
    item.current_cost = cur;
    item.move_cost    = mcost;
    return item;
  endfunction

  // Most moves come from a small corner of the matrix so that queries hit
  // pairs still held in the ring.
  function automatic tlmf_req_t random_move_item();
    tlmf_req_t item;
    int pick;
    pick = $urandom_range(0, 199);
    if (pick < 2) begin
      item.func = FUNC_CLEAR;
    end else if (pick < 12) begin
      item.func = FUNC_NOP;
    end else if (pick < 100) begin
      item.func = FUNC_COMMIT;
    end else begin
      item.func = FUNC_QUERY;
    end
    if ($urandom_range(0, 9) < 7) begin
      item.move_row = IDX_W'($urandom_range(0, 3));
      item.move_col = IDX_W'($urandom_range(0, 3));
    end else begin
      item.move_row = IDX_W'($urandom_range(0, PROBLEM_SIZE - 1));
      item.move_col = IDX_W'($urandom_range(0, PROBLEM_SIZE - 1));
    end
    case ($urandom_range(0, 3))
      0: item.current_cost = $urandom;
      1: item.current_cost = '0;
      2: item.current_cost = '1;
      default: item.current_cost = COST_W'($urandom_range(0, 1000));
    endcase
    case ($urandom_range(0, 3))
      0: item.move_cost = $urandom;
      1: item.move_cost = item.current_cost - cur_thresh + COST_W'($urandom_range(0, 2))
                          - COST_W'(1);
      2: item.move_cost = '0;
      default: item.move_cost = '1;
    endcase
    return item;
  endfunction

  task automatic send_item(input tlmf_req_t item);
    if (!calm_tail && $urandom_range(0, 99) < gap_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    case (item.func)
      FUNC_QUERY:  n_query++;
      FUNC_COMMIT: n_commit++;
      FUNC_CLEAR:  n_clear++;
      default:     n_nop++;
    endcase
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic configure(input logic [PERIOD_W-1:0] period, input logic [COST_W-1:0] thresh);
    drain();
    apb_write(ADDR_PERIOD, 32'(period));
    apb_write(ADDR_THRESH, thresh);
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    cur_thresh  = thresh;
    gap_pct     = 20 * $urandom_range(0, 2);
    n_settings++;
  endtask

  task automatic random_burst(input int count);
    repeat (count) send_item(random_move_item());
  endtask

  initial begin : responder
    forever begin
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        rsp_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: empty list, then single commits at the index extremes.
    send_item(pack_request(FUNC_QUERY, 0, 0, '0, '0));
    send_item(pack_request(FUNC_QUERY, 31, 31, '1, '0));
    send_item(pack_request(FUNC_QUERY, 31, 0, '1, '1));
    send_item(pack_request(FUNC_COMMIT, 0, 0, '0, '0));
    send_item(pack_request(FUNC_COMMIT, 31, 31, '0, '0));
    send_item(pack_request(FUNC_COMMIT, 31, 0, '1, '1));
    send_item(pack_request(FUNC_QUERY, 0, 0, 32'd5, 32'd4));
    send_item(pack_request(FUNC_QUERY, 31, 31, 32'd5, 32'd5));
    send_item(pack_request(FUNC_QUERY, 0, 31, '0, '0));
    send_item(pack_request(FUNC_NOP, 31, 31, '1, '0));
    send_item(pack_request(FUNC_COMMIT, 5, 10, '0, '0));
    send_item(pack_request(FUNC_COMMIT, 5, 10, '0, '0));
    send_item(pack_request(FUNC_QUERY, 5, 10, 32'd100, 32'd99));
    send_item(pack_request(FUNC_CLEAR, 0, 0, '0, '0));
    send_item(pack_request(FUNC_QUERY, 0, 0, '0, '0));
    send_item(pack_request(FUNC_QUERY, 31, 31, '0, '0));

    // Shortest ring and the largest threshold, where the cost bound wraps.
    configure(7'd1, '1);
    send_item(pack_request(FUNC_COMMIT, 1, 2, '0, '0));
    send_item(pack_request(FUNC_COMMIT, 3, 4, '0, '0));
    send_item(pack_request(FUNC_QUERY, 1, 2, '0, '0));
    send_item(pack_request(FUNC_QUERY, 3, 4, '0, 32'd1));
    send_item(pack_request(FUNC_COMMIT, 3, 4, '0, '0));
    send_item(pack_request(FUNC_QUERY, 3, 4, '1, '0));

    // Period changes keep the ring, so each setting starts from the last one.
    configure(7'd64, 32'h0);
    random_burst(PHASE_ITEMS);
    configure(7'd0, 32'h0000_1000);
    random_burst(PHASE_ITEMS);
    configure(7'd127, $urandom);
    random_burst(PHASE_ITEMS);
    configure(7'd4, '1);
    random_burst(PHASE_ITEMS);
    configure(7'd2, COST_W'($urandom_range(0, 255)));
    random_burst(PHASE_ITEMS);
    configure(7'd33, 32'h0);
    random_burst(PHASE_ITEMS);
    configure(PERIOD_W'($urandom_range(1, MAX_TABU_PERIOD)), $urandom);
    random_burst(PHASE_ITEMS);
    calm_tail = 1'b1;
    configure(7'd64, COST_W'($urandom_range(0, 16)));
    random_burst(PHASE_ITEMS);

    drain();
    repeat (20) @(posedge clk);
    $display("Ran %0d queries, %0d commits, %0d clears and %0d idle codes",
             n_query, n_commit, n_clear, n_nop);
    $display("under %0d register settings, periods 0 to 127, thresholds 0 to all ones.",
             n_settings);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/tlmf_pkg.sv
hdl/tlmf_ram.sv
hdl/tabu_list_move_filter.sv
tb/sv/tabu_list_move_filter_checker.sv
tb/sv/tabu_list_move_filter_tb.sv
